### design/sgm_pkg.sv
// Shared types and constants of the 3x3 Sobel gradient magnitude block.
// No dependencies; used by every other file of the block except sgm_ram.
package sgm_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned DIM_W         = 10;
  localparam int unsigned DIM_MAX       = (1 << DIM_W) - 1;
  localparam int unsigned MIN_DIM       = 3;
  localparam int unsigned MAX_WIDTH_DEF = 512;
  localparam int unsigned MAX_HEIGHT    = 512;
  localparam int unsigned DIM_RESET     = 512;
  localparam int unsigned GRAD_W        = 11;
  localparam int unsigned ABS_W         = 10;
  localparam int unsigned SQ_W          = 2 * ABS_W + 1;
  localparam int unsigned ROOT_W        = SQ_W + 1;
  localparam int unsigned ROOT_STEPS    = ROOT_W / 2;
  localparam int unsigned STEP_W        = $clog2(ROOT_STEPS);
  localparam int unsigned MAG_W         = 11;
  localparam int unsigned MAG_MAX       = 1442;

  typedef logic [PIX_W-1:0]         pixel_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [SQ_W-1:0]          sq_t;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

endpackage

### design/sgm_if.sv
// Valid/ready channels of the Sobel block: pixel requests in, gradient results out.
// Depends on sgm_pkg.
interface sgm_in_if;
  import sgm_pkg::*;
  logic   valid;
  logic   ready;
  cmd_e   cmd;
  pixel_t pixel;
  modport source (output valid, output cmd, output pixel, input ready);
  modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

interface sgm_out_if;
  import sgm_pkg::*;
  logic  valid;
  logic  ready;
  grad_t grad_x;
  grad_t grad_y;
  mag_t  magnitude;
  logic  frame_last;
  modport source (output valid, output grad_x, output grad_y, output magnitude,
                  output frame_last, input ready);
  modport sink   (input valid, input grad_x, input grad_y, input magnitude,
                  input frame_last, output ready);
endinterface

### design/sobel_gradient_magnitude_3x3.sv
// 3x3 Sobel gradient and magnitude over a raster pixel stream, line stores in RAM.
// A request is accepted only in idle and is then worked through the states read, gradient,
// square, sum and root (11-step square root unit) if it gives a result, or read alone if not;
// a dropped drain is taken in idle without leaving it. No new request is taken until idle.
// Reset clears counters, window and sizes (512 x 512); line stores are not cleared.
module sobel_gradient_magnitude_3x3 #(
  parameter int unsigned MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  sgm_pkg::cfg_idx_e  cfg_idx_i,
  input  sgm_pkg::dim_t      cfg_wdata_i,
  sgm_in_if.sink             px_i,
  sgm_out_if.source          res_o
);
  import sgm_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned WLIM = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
  localparam int unsigned HLIM = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_GRAD = 6'b000100,
    ST_SQ   = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_ROOT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  dim_t   cfg_w_q, cfg_h_q, w, h;
  dim_t   in_col_q, in_row_q, out_col_q, out_row_q;
  dim_t   col_q;
  pixel_t px_q;
  logic   emit_q, last_q;
  pixel_t win_q [3][3];
  grad_t  gx_q, gy_q, gx_d, gy_d;
  logic [2*ABS_W-1:0] sqx_q, sqy_q;
  grad_t  out_gx_q, out_gy_q;
  mag_t   out_mag_q;
  logic   out_last_q, out_valid_q;

  logic   accept, drop, load_out, last_d, in_wrap;
  pixel_t up_rd, lo_rd;
  pixel_t pm [3][3];
  logic   row_ok [3];
  logic   col_ok [3];
  logic [ABS_W:0] posx, negx, posy, negy;
  grad_t  ngx, ngy;
  logic [ABS_W-1:0] ax, ay;
  logic   root_done;
  mag_t   root;

  assign w = (cfg_w_q < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) :
             ((cfg_w_q > DIM_W'(WLIM)) ? DIM_W'(WLIM) : cfg_w_q);
  assign h = (cfg_h_q < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) :
             ((cfg_h_q > DIM_W'(HLIM)) ? DIM_W'(HLIM) : cfg_h_q);

  assign px_i.ready = (state_q == ST_IDLE);
  assign accept     = px_i.valid && px_i.ready;
  assign drop       = (px_i.cmd == CMD_DRAIN) && (in_col_q == '0) && (in_row_q == '0);
  assign in_wrap    = DIM_W'(in_col_q + 1'b1) >= w;

  sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_RD),
    .waddr_i (AW'(col_q)),
    .wdata_i (lo_rd),
    .re_i    (accept && !drop),
    .raddr_i (AW'(in_col_q)),
    .rdata_o (up_rd)
  );

  sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_lower (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_RD),
    .waddr_i (AW'(col_q)),
    .wdata_i (px_q),
    .re_i    (accept && !drop),
    .raddr_i (AW'(in_col_q)),
    .rdata_o (lo_rd)
  );

  always_comb begin
    row_ok[0] = (out_row_q != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = DIM_W'(out_row_q + 1'b1) < h;
    col_ok[0] = (out_col_q != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = DIM_W'(out_col_q + 1'b1) < w;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pm[r][c] = (row_ok[r] && col_ok[c]) ? win_q[r][c] : '0;
      end
    end
    posx = (ABS_W+1)'(pm[0][2]) + (ABS_W+1)'({pm[1][2], 1'b0}) + (ABS_W+1)'(pm[2][2]);
    negx = (ABS_W+1)'(pm[0][0]) + (ABS_W+1)'({pm[1][0], 1'b0}) + (ABS_W+1)'(pm[2][0]);
    posy = (ABS_W+1)'(pm[2][0]) + (ABS_W+1)'({pm[2][1], 1'b0}) + (ABS_W+1)'(pm[2][2]);
    negy = (ABS_W+1)'(pm[0][0]) + (ABS_W+1)'({pm[0][1], 1'b0}) + (ABS_W+1)'(pm[0][2]);
    gx_d = $signed(posx) - $signed(negx);
    gy_d = $signed(posy) - $signed(negy);
    last_d = (DIM_W'(out_row_q + 1'b1) >= h) && (DIM_W'(out_col_q + 1'b1) >= w);
    ngx = -gx_q;
    ngy = -gy_q;
    ax  = gx_q[GRAD_W-1] ? ngx[ABS_W-1:0] : gx_q[ABS_W-1:0];
    ay  = gy_q[GRAD_W-1] ? ngy[ABS_W-1:0] : gy_q[ABS_W-1:0];
  end

  sgm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_SUM),
    .radicand_i (SQ_W'(sqx_q) + SQ_W'(sqy_q)),
    .done_o     (root_done),
    .root_o     (root)
  );

  assign load_out = (state_q == ST_ROOT) && root_done && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && !drop) state_d = ST_RD;
      ST_RD:   state_d = emit_q ? ST_GRAD : ST_IDLE;
      ST_GRAD: state_d = ST_SQ;
      ST_SQ:   state_d = ST_SUM;
      ST_SUM:  state_d = ST_ROOT;
      ST_ROOT: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_w_q     <= DIM_W'(DIM_RESET);
      cfg_h_q     <= DIM_W'(DIM_RESET);
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WIDTH) begin
          cfg_w_q <= cfg_wdata_i;
        end else begin
          cfg_h_q <= cfg_wdata_i;
        end
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            win_q[r][c] <= '0;
          end
        end
      end else begin
        if (accept && !drop) begin
          if (in_wrap) begin
            in_col_q <= '0;
            if (in_row_q != DIM_W'(DIM_MAX)) in_row_q <= in_row_q + 1'b1;
          end else begin
            in_col_q <= in_col_q + 1'b1;
          end
        end
        if (state_q == ST_RD) begin
          for (int r = 0; r < 3; r++) begin
            win_q[r][0] <= win_q[r][1];
            win_q[r][1] <= win_q[r][2];
          end
          win_q[0][2] <= up_rd;
          win_q[1][2] <= lo_rd;
          win_q[2][2] <= px_q;
        end
        if (state_q == ST_GRAD) begin
          if (last_d) begin
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
            for (int r = 0; r < 3; r++) begin
              for (int c = 0; c < 3; c++) begin
                win_q[r][c] <= '0;
              end
            end
          end else if (DIM_W'(out_col_q + 1'b1) >= w) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 1'b1;
          end else begin
            out_col_q <= out_col_q + 1'b1;
          end
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q  <= in_col_q;
      px_q   <= ((px_i.cmd == CMD_DRAIN) || (in_row_q >= h)) ? '0 : px_i.pixel;
      emit_q <= (in_row_q >= DIM_W'(2)) || ((in_row_q == DIM_W'(1)) && (in_col_q != '0));
    end
    if (state_q == ST_GRAD) begin
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      last_q <= last_d;
    end
    if (state_q == ST_SQ) begin
      sqx_q <= ax * ax;
      sqy_q <= ay * ay;
    end
    if (load_out) begin
      out_gx_q   <= gx_q;
      out_gy_q   <= gy_q;
      out_mag_q  <= root;
      out_last_q <= last_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.grad_x     = out_gx_q;
  assign res_o.grad_y     = out_gy_q;
  assign res_o.magnitude  = out_mag_q;
  assign res_o.frame_last = out_last_q;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT && root_done && out_valid_q && !res_o.ready)
    |=> (state_q == ST_ROOT) && $stable(out_mag_q))
    else $error("result register overwritten while stalled");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_mag_q <= MAG_W'(MAG_MAX)))
    else $error("magnitude out of range");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT && last_q)
    |-> (in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
    else $error("counters not cleared after frame end");

endmodule

### design/sgm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sgm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sgm_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on sgm_pkg.
module sgm_isqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sgm_pkg::sq_t  radicand_i,
  output logic          done_o,
  output sgm_pkg::mag_t root_o
);
  import sgm_pkg::*;

  logic [ROOT_W-1:0] rem_q, rem_d, res_q, res_d;
  logic [ROOT_W-1:0] bit_v, trial;
  logic [STEP_W-1:0] k_q, k_d;
  logic              busy_q, busy_d, done_q, done_d;

  always_comb begin
    bit_v  = ROOT_W'(1) << {k_q, 1'b0};
    trial  = res_q + bit_v;
    rem_d  = rem_q;
    res_d  = res_q;
    k_d    = k_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = ROOT_W'(radicand_i);
      res_d  = '0;
      k_d    = STEP_W'(ROOT_STEPS - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_v;
      end else begin
        res_d = res_q >> 1;
      end
      if (k_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        k_d = k_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[MAG_W-1:0];

endmodule

### bench/sgm_grad_checker.sv
`timescale 1ns / 100ps
// Scoreboard of the 3x3 Sobel gradient block: follows the config port and both channels,
// predicts every gradient result and compares it field by field with what the block gives.
// Depends on sgm_pkg and the channel interfaces in sgm_if.
module sgm_grad_checker #(
  parameter int unsigned MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  sgm_pkg::cfg_idx_e cfg_idx_i,
  input  sgm_pkg::dim_t     cfg_wdata_i,
  sgm_in_if                 px_mon,
  sgm_out_if                res_mon,
  output int unsigned       err_count_o,
  output int unsigned       pending_o
);
  import sgm_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned ROW_CAP      = 1023;

  typedef struct {
    grad_t grad_x;
    grad_t grad_y;
    mag_t  magnitude;
    logic  frame_last;
  } grad_res_t;

  dim_t        width_reg;
  dim_t        height_reg;
  pixel_t      upper_line [MAX_WIDTH];
  pixel_t      lower_line [MAX_WIDTH];
  pixel_t      win [3][3];
  int unsigned in_col;
  int unsigned in_row;
  int unsigned out_col;
  int unsigned out_row;
  grad_res_t   expected_grads [$];

  function automatic void restart_frame();
    foreach (win[r, c]) win[r][c] = '0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic mag_t floor_root(int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 10; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= v) root = trial;
    end
    return mag_t'(root);
  endfunction

  function automatic void predict_grad(cmd_e cmd, pixel_t pix);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned pr;
    int unsigned pc;
    int          gx;
    int          gy;
    int          wx;
    int          wy;
    logic        produces;
    grad_res_t   res;
    w = (width_reg < MIN_DIM) ? MIN_DIM : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg < MIN_DIM) ? MIN_DIM :
        ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    if (cmd == CMD_DRAIN && in_col == 0 && in_row == 0) return;
    if (cmd == CMD_DRAIN || in_row >= h) pix = '0;
    col = (in_col < MAX_WIDTH) ? in_col : 0;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_line[col];
    win[1][2] = lower_line[col];
    win[2][2] = pix;
    upper_line[col] = lower_line[col];
    lower_line[col] = pix;
    produces = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      if (in_row < ROW_CAP) in_row++;
    end
    if (!produces) return;
    // mask window taps that fall outside the frame
    gx = 0;
    gy = 0;
    for (int r = 0; r < 3; r++) begin
      pr = out_row + r;
      if (pr == 0 || pr > h) continue;
      for (int c = 0; c < 3; c++) begin
        pc = out_col + c;
        if (pc == 0 || pc > w) continue;
        wx = (c - 1) * ((r == 1) ? 2 : 1);
        wy = (r - 1) * ((c == 1) ? 2 : 1);
        gx += wx * int'(win[r][c]);
        gy += wy * int'(win[r][c]);
      end
    end
    res.grad_x     = grad_t'(gx);
    res.grad_y     = grad_t'(gy);
    res.magnitude  = floor_root(gx * gx + gy * gy);
    res.frame_last = (out_row + 1 >= h) && (out_col + 1 >= w);
    expected_grads.push_back(res);
    if (res.frame_last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    grad_res_t want;
    if (!rst_ni) begin
      width_reg  = dim_t'(DIM_RESET);
      height_reg = dim_t'(DIM_RESET);
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      restart_frame();
      expected_grads.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_grads.size() == 0) begin
          if (err_count_o < REPORT_LIMIT)
            $display("%0t: unexpected result gx=%0d gy=%0d mag=%0d last=%0b", $time,
                     res_mon.grad_x, res_mon.grad_y, res_mon.magnitude, res_mon.frame_last);
          err_count_o++;
        end else begin
          want = expected_grads.pop_front();
          if (res_mon.grad_x !== want.grad_x || res_mon.grad_y !== want.grad_y ||
              res_mon.magnitude !== want.magnitude ||
              res_mon.frame_last !== want.frame_last) begin
            if (err_count_o < REPORT_LIMIT)
              $display("%0t: result differs: expected gx=%0d gy=%0d mag=%0d last=%0b, %s",
                       $time, want.grad_x, want.grad_y, want.magnitude, want.frame_last,
                       $sformatf("got gx=%0d gy=%0d mag=%0d last=%0b", res_mon.grad_x,
                                 res_mon.grad_y, res_mon.magnitude, res_mon.frame_last));
            err_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH: begin
            width_reg = cfg_wdata_i;
          end
          CFG_HEIGHT: begin
            height_reg = cfg_wdata_i;
          end
          default: begin
          end
        endcase
        restart_frame();
      end
      if (px_mon.valid && px_mon.ready) predict_grad(px_mon.cmd, px_mon.pixel);
      pending_o = expected_grads.size();
    end
  end

endmodule

### bench/sobel_gradient_magnitude_3x3_tb.sv
`timescale 1ns / 100ps
// Top of the Sobel gradient bench: clock, reset, frame stimulus and back pressure,
// with the verdict taken from sgm_grad_checker. Depends on sgm_pkg, sgm_if and the block.
module sobel_gradient_magnitude_3x3_tb;
  import sgm_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 90;

  typedef enum int unsigned {
    PAT_NOISE,
    PAT_BINARY,
    PAT_COLS,
    PAT_ROWS
  } pattern_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  dim_t        cfg_wdata;
  int unsigned err_count;
  int unsigned pending;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_cycles  = 0;
  int unsigned items_sent   = 0;
  dim_t        cur_w;
  dim_t        cur_h;

  sgm_in_if  px_if ();
  sgm_out_if res_if ();

  sobel_gradient_magnitude_3x3 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .px_i        (px_if.sink),
    .res_o       (res_if.source)
  );

  sgm_grad_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .px_mon      (px_if),
    .res_mon     (res_if),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result sink: random stalls, or a long hold-off when one is requested
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        res_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    #400_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned eff_dim(dim_t v, int unsigned cap);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic pixel_t pick_pixel(pattern_e pat, int unsigned k, int unsigned w,
                                        int unsigned h);
    case (pat)
      PAT_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
      PAT_COLS:   return ((k % w) >= w / 2) ? 8'hFF : 8'h00;
      PAT_ROWS:   return ((k / w) >= h / 2) ? 8'hFF : 8'h00;
      default:    return pixel_t'($urandom);
    endcase
  endfunction

  function automatic dim_t rand_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return dim_t'($urandom_range(2));
    if (r < 20) return dim_t'($urandom_range(16, 10));
    return dim_t'($urandom_range(8, 3));
  endfunction

  task automatic send_item(cmd_e c, pixel_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      px_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    px_if.valid <= 1'b1;
    px_if.cmd   <= c;
    px_if.pixel <= p;
    @(posedge clk_i);
    while (!px_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    px_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, dim_t val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic set_dims(dim_t w, dim_t h);
    wait_drained();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // a whole frame is w*h pixels plus w+1 padding requests; cut stops it early
  task automatic send_frame(pattern_e pat, int unsigned drain_pct, int unsigned cut);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    cmd_e        c;
    w = eff_dim(cur_w, MAX_WIDTH_DEF);
    h = eff_dim(cur_h, MAX_HEIGHT);
    total = (h + 1) * w + 1;
    if (cut != 0 && cut < total) total = cut;
    repeat (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0)
      send_item(CMD_DRAIN, pixel_t'($urandom));
    for (int unsigned k = 0; k < total; k++) begin
      if (k < w * h)
        c = (k != 0 && $urandom_range(99) < drain_pct) ? CMD_DRAIN : CMD_PIXEL;
      else
        c = ($urandom_range(99) < 25) ? CMD_PIXEL : CMD_DRAIN;
      send_item(c, pick_pixel(pat, k, w, h));
      items_sent++;
    end
  endtask

  task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, int unsigned budget);
    int unsigned start;
    bit          restart_due;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start = items_sent;
    restart_due = 1'b1;
    while (items_sent - start < budget) begin
      if (restart_due || $urandom_range(3) != 0) set_dims(rand_dim(), rand_dim());
      if ($urandom_range(99) < 15) begin
        send_frame(pattern_e'($urandom_range(3)), 5, $urandom_range(40, 1));
        restart_due = 1'b1;
      end else begin
        send_frame(pattern_e'($urandom_range(3)), $urandom_range(1) ? 0 : 6, 0);
        restart_due = 1'b0;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_WIDTH;
    cfg_wdata   <= '0;
    px_if.valid <= 1'b0;
    px_if.cmd   <= CMD_PIXEL;
    px_if.pixel <= '0;
    cur_w = dim_t'(DIM_RESET);
    cur_h = dim_t'(DIM_RESET);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_pct = 37;
    snk_idle_pct = 50;

    // reset sizes: part of the first row, then abandon the frame
    for (int k = 0; k < 40; k++) send_item(CMD_PIXEL, pixel_t'($urandom));

    // clamped 3x3, ignored drain, strongest edges, pixel in the padding, drain in the frame
    set_dims(dim_t'(0), dim_t'(2));
    send_item(CMD_DRAIN, 8'hA5);
    for (int k = 0; k < 9; k++) send_item(CMD_PIXEL, (k % 3 == 2) ? 8'hFF : 8'h00);
    send_item(CMD_PIXEL, 8'hFF);
    repeat (3) send_item(CMD_DRAIN, 8'hFF);
    for (int k = 0; k < 9; k++)
      send_item((k == 4) ? CMD_DRAIN : CMD_PIXEL, (k % 3 == 0) ? 8'hFF : 8'h00);
    repeat (4) send_item(CMD_DRAIN, 8'h00);

    run_phase(37, 50, PHASE_ITEMS);
    run_phase(50, 37, PHASE_ITEMS);
    run_phase(0, 0, PHASE_ITEMS);

    // hold the sink so the block backs up, then start clamped oversize frames
    set_dims(dim_t'(16), dim_t'(4));
    hold_cycles = 200;
    send_frame(PAT_NOISE, 0, 0);
    set_dims(dim_t'(3), dim_t'(1023));
    send_frame(PAT_COLS, 2, 60);
    set_dims(dim_t'(1023), dim_t'(1023));
    send_frame(PAT_NOISE, 0, 30);
    wait_drained();

    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
